FILE: hdl/lcs_pkg.sv
// Shared types and codes for the line diff unit.
package lcs_pkg;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 32;
  localparam int KIND_W = 2;
  localparam int LINE_W = 6;

  localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN        = 2'd2;

  localparam logic [KIND_W-1:0] KIND_EQUAL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] line_key;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] edit_kind;
    logic [LINE_W-1:0] left_line;
    logic [LINE_W-1:0] right_line;
    logic              last;
  } out_item_t;

endpackage

FILE: hdl/lcs_line_diff_unit.sv
// Line diff unit: loads two key lists and emits an LCS edit script per run.
// A run with both lists non-empty first fills the suffix LCS table one cell per cycle
// through the table's single fill read port, left_count * right_count cells, then
// drains the cell pipeline (a run with one list empty skips the fill), then walks the
// table edit by edit, reading the two neighbor cells and both keys and then deciding
// and registering each edit, stretched by any output stall. The unit takes no input
// beat during a run; loads for the next run are taken while the final edit still waits
// on the output. The table needs no clearing pass: cells on the bounding row and column
// of a run read as zero and every other cell a run reads is written by that run first.
module lcs_line_diff_unit #(
  parameter int MAX_LINES = 32,
  parameter int KEY_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcs_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lcs_pkg::out_item_t out_data
);

  localparam int COLS      = MAX_LINES + 1;
  localparam int TBL_DEPTH = COLS * COLS;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CELL_W    = $clog2(MAX_LINES + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_FILL    = 3'd1;
  localparam logic [2:0] ST_FLUSH   = 3'd2;
  localparam logic [2:0] ST_WALK_RD = 3'd3;
  localparam logic [2:0] ST_WALK_EM = 3'd4;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] row,
                                                  input logic [CNT_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  lcnt_r, rcnt_r;
  logic [CNT_W-1:0]  fi_r, fj_r;
  logic [CNT_W-1:0]  wl_r, wr_r;

  logic [KEY_BITS-1:0] lmem [MAX_LINES];
  logic [KEY_BITS-1:0] rmem [MAX_LINES];
  logic [KEY_BITS-1:0] lk_q_r, rk_q_r;
  logic [CELL_W-1:0]   tbl [TBL_DEPTH];
  logic [CELL_W-1:0]   ta_q_r, tb_q_r;

  logic              s1_v_r, s1_first_r, s1_bot_r, s1_byp_r;
  logic [CNT_W-1:0]  s1_i_r, s1_j_r;
  logic [CELL_W-1:0] s1_wd_r, prev_down_r, prev_val_r;

  logic               out_valid_r;
  lcs_pkg::out_item_t out_data_r;

  logic [KEY_BITS-1:0] key_in;
  logic                in_fire, lmem_we, rmem_we, key_re, issuing;
  logic [IDX_W-1:0]    lk_ra, rk_ra;
  logic [ADDR_W-1:0]   ta_ra, tb_ra, t_wa;
  logic [CELL_W-1:0]   down_c, diag_c, across_c, val_c;
  logic                l_lt, r_lt, w_eq, w_add, w_last, out_free;
  logic [CELL_W-1:0]   a_val, b_val;
  logic [CNT_W-1:0]    nl_c, nr_c;

  generate
    if (KEY_BITS <= lcs_pkg::KEY_W) begin : g_key_trunc
      assign key_in = in_data.line_key[KEY_BITS-1:0];
    end else begin : g_key_ext
      assign key_in = {{(KEY_BITS - lcs_pkg::KEY_W){1'b0}}, in_data.line_key};
    end
  endgenerate

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign lmem_we  = in_fire && (in_data.command == lcs_pkg::CMD_LOAD_LEFT) &&
                    (lcnt_r < CNT_W'(MAX_LINES));
  assign rmem_we  = in_fire && (in_data.command == lcs_pkg::CMD_LOAD_RIGHT) &&
                    (rcnt_r < CNT_W'(MAX_LINES));
  assign issuing  = (state_r == ST_FILL);
  assign key_re   = issuing || (state_r == ST_WALK_RD);
  assign lk_ra    = issuing ? fi_r[IDX_W-1:0] : wl_r[IDX_W-1:0];
  assign rk_ra    = issuing ? fj_r[IDX_W-1:0] : wr_r[IDX_W-1:0];
  assign ta_ra    = issuing ? cell_addr(fi_r + CNT_W'(1), fj_r)
                            : cell_addr(wl_r, wr_r + CNT_W'(1));
  assign tb_ra    = cell_addr(wl_r + CNT_W'(1), wr_r);
  assign t_wa     = cell_addr(s1_i_r, s1_j_r);

  always_ff @(posedge clk) begin
    if (lmem_we) lmem[lcnt_r[IDX_W-1:0]] <= key_in;
    if (rmem_we) rmem[rcnt_r[IDX_W-1:0]] <= key_in;
    if (key_re) begin
      lk_q_r <= lmem[lk_ra];
      rk_q_r <= rmem[rk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) tbl[t_wa] <= val_c;
    if (issuing || (state_r == ST_WALK_RD)) ta_q_r <= tbl[ta_ra];
    if (state_r == ST_WALK_RD) tb_q_r <= tbl[tb_ra];
  end

  assign down_c   = s1_bot_r ? '0 : (s1_byp_r ? s1_wd_r : ta_q_r);
  assign diag_c   = s1_first_r ? '0 : prev_down_r;
  assign across_c = s1_first_r ? '0 : prev_val_r;
  assign val_c    = (lk_q_r == rk_q_r) ? diag_c + CELL_W'(1)
                                       : ((down_c > across_c) ? down_c : across_c);

  assign l_lt   = wl_r < lcnt_r;
  assign r_lt   = wr_r < rcnt_r;
  assign w_eq   = l_lt && r_lt && (lk_q_r == rk_q_r);
  assign a_val  = ((wr_r + CNT_W'(1)) == rcnt_r) ? '0 : ta_q_r;
  assign b_val  = ((wl_r + CNT_W'(1)) == lcnt_r) ? '0 : tb_q_r;
  assign w_add  = !w_eq && r_lt && (!l_lt || (a_val >= b_val));
  assign nl_c   = (w_eq || !w_add) ? wl_r + CNT_W'(1) : wl_r;
  assign nr_c   = (w_eq || w_add) ? wr_r + CNT_W'(1) : wr_r;
  assign w_last = (nl_c == lcnt_r) && (nr_c == rcnt_r);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.command == lcs_pkg::CMD_RUN)) begin
          if ((lcnt_r != '0) && (rcnt_r != '0)) state_nxt = ST_FILL;
          else if ((lcnt_r != '0) || (rcnt_r != '0)) state_nxt = ST_WALK_RD;
        end
      end
      ST_FILL:    if ((fi_r == '0) && (fj_r == '0)) state_nxt = ST_FLUSH;
      ST_FLUSH:   state_nxt = ST_WALK_RD;
      ST_WALK_RD: state_nxt = ST_WALK_EM;
      ST_WALK_EM: if (out_free) state_nxt = w_last ? ST_IDLE : ST_WALK_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lcnt_r      <= '0;
      rcnt_r      <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issuing;
      if (lmem_we) lcnt_r <= lcnt_r + CNT_W'(1);
      if (rmem_we) rcnt_r <= rcnt_r + CNT_W'(1);
      if ((state_r == ST_WALK_EM) && out_free) begin
        out_valid_r <= 1'b1;
        if (w_last) begin
          lcnt_r <= '0;
          rcnt_r <= '0;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        fi_r <= lcnt_r - CNT_W'(1);
        fj_r <= rcnt_r - CNT_W'(1);
        wl_r <= '0;
        wr_r <= '0;
      end
      ST_FILL: begin
        s1_i_r     <= fi_r;
        s1_j_r     <= fj_r;
        s1_first_r <= (fj_r == rcnt_r - CNT_W'(1));
        s1_bot_r   <= ((fi_r + CNT_W'(1)) == lcnt_r);
        s1_byp_r   <= s1_v_r && (t_wa == ta_ra);
        s1_wd_r    <= val_c;
        if (fj_r == '0) begin
          fi_r <= fi_r - CNT_W'(1);
          fj_r <= rcnt_r - CNT_W'(1);
        end else begin
          fj_r <= fj_r - CNT_W'(1);
        end
      end
      ST_WALK_EM: begin
        if (out_free) begin
          wl_r <= nl_c;
          wr_r <= nr_c;
          out_data_r.edit_kind  <= w_eq ? lcs_pkg::KIND_EQUAL :
                                   (w_add ? lcs_pkg::KIND_ADDED : lcs_pkg::KIND_REMOVED);
          out_data_r.left_line  <= (w_eq || !w_add) ?
                                   lcs_pkg::LINE_W'(wl_r) + lcs_pkg::LINE_W'(1) : '0;
          out_data_r.right_line <= (w_eq || w_add) ?
                                   lcs_pkg::LINE_W'(wr_r) + lcs_pkg::LINE_W'(1) : '0;
          out_data_r.last       <= w_last;
        end
      end
      default: begin
      end
    endcase
    if (s1_v_r) begin
      prev_down_r <= down_c;
      prev_val_r  <= val_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/lcs_checker.sv
// Port-level checks for the line diff unit, bound to its top level.
module lcs_checker #(
  parameter int MAX_LINES = 32
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input lcs_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input lcs_pkg::out_item_t out_data
);

  localparam logic [lcs_pkg::LINE_W-1:0] MAX_LINE = lcs_pkg::LINE_W'(MAX_LINES);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_kind_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.edit_kind == lcs_pkg::KIND_EQUAL &&
       out_data.left_line != '0 && out_data.right_line != '0) ||
      (out_data.edit_kind == lcs_pkg::KIND_ADDED &&
       out_data.left_line == '0 && out_data.right_line != '0) ||
      (out_data.edit_kind == lcs_pkg::KIND_REMOVED &&
       out_data.left_line != '0 && out_data.right_line == '0))
    else $error("edit kind does not match its line numbers");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.left_line <= MAX_LINE && out_data.right_line <= MAX_LINE)
    else $error("line number beyond capacity");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input taken before the run finished");

endmodule

bind lcs_line_diff_unit lcs_checker #(.MAX_LINES(MAX_LINES)) u_lcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for lcs_line_diff_unit: load and run beats checked against an LCS edit predictor.
module tb;

  localparam int MAXL        = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int ITEM_GOAL   = 410;
  localparam int LW          = lcs_pkg::LINE_W;
  localparam logic [lcs_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  lcs_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  lcs_pkg::out_item_t out_data;

  lcs_line_diff_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [lcs_pkg::KEY_W-1:0] lhs_key [MAXL];
  logic [lcs_pkg::KEY_W-1:0] rhs_key [MAXL];
  int                        lhs_n;
  int                        rhs_n;
  logic [LW-1:0]             suffix_len [MAXL+1][MAXL+1];
  lcs_pkg::out_item_t        edit_q [$];

  int                 item_cnt;
  int                 load_cnt;
  int                 run_cnt;
  int                 edit_cnt = 0;
  int                 seen_cnt = 0;
  int                 err_cnt = 0;
  int                 longest;
  int                 ready_hold = 0;
  int                 quiet = 0;
  bit                 idle_on;
  lcs_pkg::out_item_t want;

  function automatic void predict_script();
    int i;
    int j;
    int l;
    int r;
    int n;
    logic [LW-1:0] down;
    logic [LW-1:0] across;
    lcs_pkg::out_item_t e;
    for (j = 0; j <= rhs_n; j++) suffix_len[lhs_n][j] = '0;
    for (i = 0; i <= lhs_n; i++) suffix_len[i][rhs_n] = '0;
    for (i = lhs_n - 1; i >= 0; i--) begin
      for (j = rhs_n - 1; j >= 0; j--) begin
        if (lhs_key[i] == rhs_key[j]) begin
          suffix_len[i][j] = suffix_len[i+1][j+1] + LW'(1);
        end else begin
          down   = suffix_len[i+1][j];
          across = suffix_len[i][j+1];
          suffix_len[i][j] = (down > across) ? down : across;
        end
      end
    end
    l = 0;
    r = 0;
    n = 0;
    while ((l < lhs_n || r < rhs_n) && n < 2 * MAXL) begin
      if (l < lhs_n && r < rhs_n && lhs_key[l] == rhs_key[r]) begin
        e.edit_kind  = lcs_pkg::KIND_EQUAL;
        e.left_line  = LW'(l + 1);
        e.right_line = LW'(r + 1);
        l++;
        r++;
      end else if (r < rhs_n &&
                   (l == lhs_n || suffix_len[l][r+1] >= suffix_len[l+1][r])) begin
        e.edit_kind  = lcs_pkg::KIND_ADDED;
        e.left_line  = '0;
        e.right_line = LW'(r + 1);
        r++;
      end else begin
        e.edit_kind  = lcs_pkg::KIND_REMOVED;
        e.left_line  = LW'(l + 1);
        e.right_line = '0;
        l++;
      end
      n++;
      e.last = (l == lhs_n && r == rhs_n) || n == 2 * MAXL;
      edit_q.push_back(e);
    end
    lhs_n = 0;
    rhs_n = 0;
    run_cnt++;
    if (n > longest) longest = n;
  endfunction

  function automatic void apply_beat(lcs_pkg::in_item_t it);
    case (it.command)
      lcs_pkg::CMD_LOAD_LEFT: begin
        if (lhs_n < MAXL) begin
          lhs_key[lhs_n] = it.line_key;
          lhs_n++;
          load_cnt++;
          item_cnt++;
        end
      end
      lcs_pkg::CMD_LOAD_RIGHT: begin
        if (rhs_n < MAXL) begin
          rhs_key[rhs_n] = it.line_key;
          rhs_n++;
          load_cnt++;
          item_cnt++;
        end
      end
      lcs_pkg::CMD_RUN: begin
        predict_script();
        item_cnt++;
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(input logic [lcs_pkg::CMD_W-1:0] cmd,
                           input logic [lcs_pkg::KEY_W-1:0] key);
    int gap;
    lcs_pkg::in_item_t it;
    it.command  = cmd;
    it.line_key = key;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    apply_beat(it);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      edit_cnt++;
      if (edit_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("edit %0d: none expected, got kind %0d left %0d right %0d last %0b",
                   edit_cnt, out_data.edit_kind, out_data.left_line, out_data.right_line,
                   out_data.last);
      end else begin
        want = edit_q.pop_front();
        if (want.edit_kind !== out_data.edit_kind || want.left_line !== out_data.left_line ||
            want.right_line !== out_data.right_line || want.last !== out_data.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("edit %0d: expected kind %0d left %0d right %0d last %0b, %s%0d %s%0d %s%0d %s%0b",
                     edit_cnt, want.edit_kind, want.left_line, want.right_line, want.last,
                     "got kind ", out_data.edit_kind, "left ", out_data.left_line,
                     "right ", out_data.right_line, "last ", out_data.last);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (edit_cnt != seen_cnt) begin
        seen_cnt   = edit_cnt;
        ready_hold = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d edits pending", quiet, edit_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_directed_edges();
    idle_on = 1'b0;
    send_beat(lcs_pkg::CMD_RUN, 32'h0);
    send_beat(CMD_SPARE, 32'hFFFF_FFFF);
    send_beat(lcs_pkg::CMD_LOAD_LEFT, 32'h0);
    send_beat(lcs_pkg::CMD_LOAD_LEFT, 32'hFFFF_FFFF);
    send_beat(lcs_pkg::CMD_RUN, 32'hFFFF_FFFF);
    send_beat(lcs_pkg::CMD_LOAD_RIGHT, 32'h1234_5678);
    send_beat(lcs_pkg::CMD_RUN, 32'h0);
    send_beat(lcs_pkg::CMD_LOAD_LEFT, 32'hA);
    send_beat(lcs_pkg::CMD_LOAD_RIGHT, 32'hB);
    send_beat(lcs_pkg::CMD_LOAD_LEFT, 32'hB);
    send_beat(lcs_pkg::CMD_LOAD_RIGHT, 32'hD);
    send_beat(lcs_pkg::CMD_LOAD_LEFT, 32'hC);
    send_beat(lcs_pkg::CMD_LOAD_RIGHT, 32'hC);
    send_beat(lcs_pkg::CMD_RUN, 32'h0);
    send_beat(lcs_pkg::CMD_LOAD_LEFT, 32'hFFFF_FFFF);
    send_beat(lcs_pkg::CMD_LOAD_RIGHT, 32'h0);
    send_beat(lcs_pkg::CMD_RUN, 32'h0);
    send_beat(lcs_pkg::CMD_LOAD_RIGHT, 32'hFFFF_FFFF);
    send_beat(lcs_pkg::CMD_LOAD_LEFT, 32'hFFFF_FFFF);
    send_beat(lcs_pkg::CMD_RUN, 32'h0);
  endtask

  task automatic test_capacity();
    int i;
    idle_on = 1'b1;
    for (i = 0; i < MAXL + 2; i++)
      send_beat(lcs_pkg::CMD_LOAD_LEFT, {1'b0, 31'($urandom)});
    for (i = 0; i < MAXL + 1; i++)
      send_beat(lcs_pkg::CMD_LOAD_RIGHT, {1'b1, 31'($urandom)});
    send_beat(lcs_pkg::CMD_RUN, $urandom);
  endtask

  task automatic test_random_scripts();
    int i;
    int nl;
    int nr;
    int pick;
    int alpha_n;
    int seq;
    logic [lcs_pkg::KEY_W-1:0] alpha [8];
    seq = 0;
    while (item_cnt < ITEM_GOAL) begin
      if (seq % 12 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        nl = $urandom_range(0, 8);
        nr = $urandom_range(0, 8);
      end else if (pick < 95) begin
        nl = $urandom_range(9, 20);
        nr = $urandom_range(9, 20);
      end else begin
        nl = $urandom_range(28, MAXL + 2);
        nr = $urandom_range(28, MAXL + 2);
      end
      alpha_n = $urandom_range(1, 6);
      for (i = 0; i < alpha_n; i++) alpha[i] = $urandom;
      if ($urandom_range(0, 4) == 0) begin
        alpha[0] = '0;
        alpha[1] = '1;
      end
      while (nl > 0 || nr > 0) begin
        if ($urandom_range(0, 19) == 0) send_beat(CMD_SPARE, $urandom);
        if (nl > 0 && (nr == 0 || $urandom_range(0, 1) == 1)) begin
          send_beat(lcs_pkg::CMD_LOAD_LEFT, alpha[$urandom_range(0, alpha_n - 1)]);
          nl--;
        end else begin
          send_beat(lcs_pkg::CMD_LOAD_RIGHT, alpha[$urandom_range(0, alpha_n - 1)]);
          nr--;
        end
      end
      if ($urandom_range(0, 19) != 0) send_beat(lcs_pkg::CMD_RUN, $urandom);
      if ($urandom_range(0, 24) == 0) send_beat(lcs_pkg::CMD_RUN, $urandom);
      seq++;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    idle_on    = 1'b0;
    lhs_n      = 0;
    rhs_n      = 0;
    item_cnt   = 0;
    load_cnt   = 0;
    run_cnt    = 0;
    longest    = 0;
    for (int i = 0; i < MAXL; i++) begin
      lhs_key[i] = '0;
      rhs_key[i] = '0;
    end
    for (int i = 0; i <= MAXL; i++)
      for (int j = 0; j <= MAXL; j++) suffix_len[i][j] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_capacity();
    test_random_scripts();

    @(negedge clk);
    in_valid <= 1'b0;
    while (edit_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Loaded %0d keys over %0d comparisons, including overfull and empty lists.",
             load_cnt, run_cnt);
    $display("Checked %0d edits, longest script %0d edits, %0d mismatches.",
             edit_cnt, longest, err_cnt);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lcs_pkg.sv
hdl/lcs_line_diff_unit.sv
hdl/lcs_checker.sv
sim/tb.sv
